### rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// Device presence table: shared definitions
// Table sizing, command and status codes, the stored entry layout and the
// structures passed between the sequencer, the totals block and the top level.
// ----------------------------------------------------------------------------
package dpt_pkg;

  // Table sizing and derived widths.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 4;
  localparam int ALERT_W  = 2;
  localparam int COUNT_W  = 6;

  localparam logic [BYTE_W-1:0] ID_MAX       = 8'd247;
  localparam logic [BYTE_W-1:0] SRC_MANUAL   = 8'd1;
  localparam logic [BYTE_W-1:0] SRC_FAILSAFE = 8'd2;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd310000;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_ADDED        = 4'd0,
    RS_UPDATED      = 4'd1,
    RS_CAME_ONLINE  = 4'd2,
    RS_FULL         = 4'd3,
    RS_DUPLICATE    = 4'd4,
    RS_NOT_FOUND    = 4'd5,
    RS_BAD_ID       = 4'd6,
    RS_FOUND        = 4'd7,
    RS_WENT_OFFLINE = 4'd8,
    RS_SWEEP_DONE   = 4'd9
  } status_t;

  typedef enum logic [ALERT_W-1:0] {
    AL_NONE    = 2'd0,
    AL_WARNING = 2'd1,
    AL_ERROR   = 2'd2
  } alert_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP1,
    S_SWEEP2
  } state_t;

  // One stored table entry.
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] profile;
    logic              online;
    logic [BYTE_W-1:0] relays;
    logic [BYTE_W-1:0] source;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result transaction from the sequencer, before the totals are attached.
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [BYTE_W-1:0] id;
    logic              online;
    logic [BYTE_W-1:0] profile;
    logic [BYTE_W-1:0] relays;
    logic [BYTE_W-1:0] source;
    alert_t            alert;
    logic              last;
  } res_t;

  // Changes to the table totals caused by one step.
  typedef struct packed {
    logic              add;
    logic              report;
    logic              was_off;
    logic [BYTE_W-1:0] old_src;
    logic [BYTE_W-1:0] new_src;
    logic              sweep_sub;
    logic [CNT_W-1:0]  off_cnt;
  } stats_upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] online;
    logic [CNT_W-1:0] manual;
    logic [CNT_W-1:0] failsafe;
  } counts_t;

endpackage

### rtl/device_presence_table.sv
// ----------------------------------------------------------------------------
// Device presence table
// Table of registered devices with add, status report, timeout sweep and
// lookup commands; all entries live in one entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low; the in_ ports are sampled at that edge. Every result transaction is
//   shown on the out_ ports for one cycle with out_strobe high, and out_last
//   marks the final result of a command. The receiver cannot stall results.
//   Add, status report and lookup give one result. A rejection that needs no
//   table access (full table, bad id) appears in the next cycle and leaves
//   the block free. Otherwise the entries are read one per cycle from the
//   memory up to the match or the last registered entry, and busy falls as
//   the result appears. A sweep reads the table twice (a counting pass, then
//   the pass that marks entries offline and reports them), one entry at a
//   time through the single memory read port. cfg_write_en / cfg_write_data
//   load the offline timeout; the user is to write it only while idle, as
//   the block itself does not enforce this.
//   Reset empties the table and loads the timeout with its default; the
//   memory needs no clearing, since only registered entries are read.
// ----------------------------------------------------------------------------
module device_presence_table import dpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [BYTE_W-1:0]   in_device_id,
  input  logic [BYTE_W-1:0]   in_profile,
  input  logic [BYTE_W-1:0]   in_relay_state,
  input  logic [BYTE_W-1:0]   in_control_source,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0]   out_result_id,
  output logic                out_is_online,
  output logic [BYTE_W-1:0]   out_entry_profile,
  output logic [BYTE_W-1:0]   out_entry_relays,
  output logic [BYTE_W-1:0]   out_entry_source,
  output logic [ALERT_W-1:0]  out_alert_level,
  output logic [COUNT_W-1:0]  out_total_count,
  output logic [COUNT_W-1:0]  out_online_count,
  output logic [COUNT_W-1:0]  out_manual_count,
  output logic [COUNT_W-1:0]  out_failsafe_count,
  output logic                out_last,
  input  logic                cfg_write_en,
  input  logic [TIME_W-1:0]   cfg_write_data
);

  logic [TIME_W-1:0] timeout_r;
  logic [IDX_W-1:0]  ram_raddr, ram_waddr;
  logic              ram_we;
  entry_t            ram_rdata, ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata_bits;
  res_t              res;
  stats_upd_t        upd;
  counts_t           cnt, cnt_nxt;
  logic              strobe_r;
  res_t              res_r;
  counts_t           cnt_out_r;

  // Offline timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_r <= cfg_write_data;
    end
  end

  dpt_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_device_id      (in_device_id),
    .in_profile        (in_profile),
    .in_relay_state    (in_relay_state),
    .in_control_source (in_control_source),
    .in_now_ms         (in_now_ms),
    .timeout           (timeout_r),
    .used              (cnt.total),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .res               (res),
    .upd               (upd)
  );

  dpt_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .cnt     (cnt),
    .cnt_nxt (cnt_nxt)
  );

  dpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_bits)
  );

  assign ram_rdata = entry_t'(ram_rdata_bits);

  // Result register: the totals taken are those after the step's changes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      res_r     <= res;
      cnt_out_r <= cnt_nxt;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = res_r.status;
  assign out_result_id      = res_r.id;
  assign out_is_online      = res_r.online;
  assign out_entry_profile  = res_r.profile;
  assign out_entry_relays   = res_r.relays;
  assign out_entry_source   = res_r.source;
  assign out_alert_level    = res_r.alert;
  assign out_last           = res_r.last;
  assign out_total_count    = COUNT_W'(cnt_out_r.total);
  assign out_online_count   = COUNT_W'(cnt_out_r.online);
  assign out_manual_count   = COUNT_W'(cnt_out_r.manual);
  assign out_failsafe_count = COUNT_W'(cnt_out_r.failsafe);

  // The final result of a command is shown only once the block is free.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("final result shown while still busy");

endmodule

### rtl/dpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module dpt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/dpt_stats.sv
// ----------------------------------------------------------------------------
// Device presence table: totals
// Keeps the registered, online, manual and failsafe counts up to date from
// the changes that each step reports, and offers their next values.
// ----------------------------------------------------------------------------
module dpt_stats import dpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stats_upd_t upd,
  output counts_t    cnt,
  output counts_t    cnt_nxt
);

  counts_t cnt_r;

  // Next totals: an add grows the table, a report may move an entry online
  // and between sources, and the end of the first sweep pass takes the
  // expired entries off the online count.
  always_comb begin
    cnt_nxt.total    = cnt_r.total + CNT_W'(upd.add);
    cnt_nxt.online   = cnt_r.online + CNT_W'(upd.report && upd.was_off)
                       - (upd.sweep_sub ? upd.off_cnt : '0);
    cnt_nxt.manual   = cnt_r.manual
                       - CNT_W'(upd.report && (upd.old_src == SRC_MANUAL))
                       + CNT_W'(upd.report && (upd.new_src == SRC_MANUAL));
    cnt_nxt.failsafe = cnt_r.failsafe
                       - CNT_W'(upd.report && (upd.old_src == SRC_FAILSAFE))
                       + CNT_W'(upd.report && (upd.new_src == SRC_FAILSAFE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

  // The online count never exceeds the number of registered devices.
  a_online_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r.online <= cnt_r.total)
    else $error("online count exceeds registered count");

  // An entry is manual or failsafe, never both.
  a_sources_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r.manual} + {1'b0, cnt_r.failsafe}) <= {1'b0, cnt_r.total})
    else $error("manual and failsafe counts exceed registered count");

endmodule

### rtl/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// Device presence table: sequencer
// Latches a command, scans the entry memory with a one-deep read pipeline,
// modifies and writes back entries, and produces the result transactions.
// ----------------------------------------------------------------------------
module dpt_ctrl import dpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [BYTE_W-1:0]  in_device_id,
  input  logic [BYTE_W-1:0]  in_profile,
  input  logic [BYTE_W-1:0]  in_relay_state,
  input  logic [BYTE_W-1:0]  in_control_source,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic [TIME_W-1:0]  timeout,
  input  logic [CNT_W-1:0]   used,
  output logic [IDX_W-1:0]   ram_raddr,
  input  entry_t             ram_rdata,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output entry_t             ram_wdata,
  output res_t               res,
  output stats_upd_t         upd
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] id_r, prof_r, relay_r, src_r;
  logic [TIME_W-1:0] now_r;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic              pv_r, pv_nxt;
  logic [CNT_W-1:0]  off_cnt_r, off_cnt_nxt;

  cmd_t              in_cmd;
  logic              accept;
  logic              id_ok;
  logic              table_full;
  logic              more;
  logic              fin;
  logic              hit;
  logic [TIME_W-1:0] age;
  logic              expired;
  alert_t            rep_alert;

  // Command decode and scan status.
  assign in_cmd     = cmd_t'(in_command);
  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign id_ok      = (in_device_id != '0) && (in_device_id <= ID_MAX);
  assign table_full = (used >= CNT_W'(TABLE_DEPTH));
  assign more       = (rd_idx_r < used);
  assign fin        = !pv_r && !more;
  assign hit        = pv_r && (ram_rdata.id == id_r);
  assign age        = now_r - ram_rdata.last_seen;
  assign expired    = pv_r && ram_rdata.online && (age > timeout);
  assign ram_raddr  = rd_idx_r[IDX_W-1:0];

  // Alert raised by a status report whose control source changed to manual (warning) or failsafe (error).
  always_comb begin
    rep_alert = AL_NONE;
    if (ram_rdata.source != src_r) begin
      if (src_r == SRC_MANUAL) begin
        rep_alert = AL_WARNING;
      end else if (src_r == SRC_FAILSAFE) begin
        rep_alert = AL_ERROR;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ADD: begin
              if (!table_full && id_ok) state_nxt = S_SCAN;
            end
            CMD_REPORT, CMD_LOOKUP: begin
              if (id_ok) state_nxt = S_SCAN;
            end
            CMD_SWEEP: begin
              state_nxt = S_SWEEP1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit || fin) state_nxt = S_IDLE;
      end
      S_SWEEP1: begin
        if (fin) state_nxt = S_SWEEP2;
      end
      S_SWEEP2: begin
        if (fin) state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs: read pipeline, memory write-back, results and total changes.
  always_comb begin
    res         = '0;
    upd         = '0;
    ram_we      = 1'b0;
    ram_waddr   = pidx_r;
    ram_wdata   = ram_rdata;
    rd_idx_nxt  = rd_idx_r;
    pidx_nxt    = pidx_r;
    pv_nxt      = 1'b0;
    off_cnt_nxt = off_cnt_r;

    // Issue the next read while a scan is running.
    if ((state_r != S_IDLE) && more) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
      pidx_nxt   = rd_idx_r[IDX_W-1:0];
      pv_nxt     = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        rd_idx_nxt  = '0;
        off_cnt_nxt = '0;
        // Rejections that need no table access answer at once.
        if (accept) begin
          unique case (in_cmd)
            CMD_ADD: begin
              if (table_full) begin
                res.valid  = 1'b1;
                res.status = RS_FULL;
                res.id     = in_device_id;
                res.last   = 1'b1;
              end else if (!id_ok) begin
                res.valid  = 1'b1;
                res.status = RS_BAD_ID;
                res.id     = in_device_id;
                res.last   = 1'b1;
              end
            end
            CMD_REPORT, CMD_LOOKUP: begin
              if (!id_ok) begin
                res.valid  = 1'b1;
                res.status = RS_BAD_ID;
                res.id     = in_device_id;
                res.last   = 1'b1;
              end
            end
            CMD_SWEEP: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res.valid   = 1'b1;
          res.id      = id_r;
          res.online  = ram_rdata.online;
          res.profile = ram_rdata.profile;
          res.relays  = ram_rdata.relays;
          res.source  = ram_rdata.source;
          res.last    = 1'b1;
          case (cmd_r)
            CMD_ADD: begin
              res.status = RS_DUPLICATE;
            end
            CMD_LOOKUP: begin
              res.status = RS_FOUND;
            end
            CMD_REPORT: begin
              // Refresh the entry and write it back in place.
              ram_we              = 1'b1;
              ram_wdata.online    = 1'b1;
              ram_wdata.relays    = relay_r;
              ram_wdata.source    = src_r;
              ram_wdata.last_seen = now_r;
              res.status  = ram_rdata.online ? RS_UPDATED : RS_CAME_ONLINE;
              res.online  = 1'b1;
              res.relays  = relay_r;
              res.source  = src_r;
              res.alert   = rep_alert;
              upd.report  = 1'b1;
              upd.was_off = !ram_rdata.online;
              upd.old_src = ram_rdata.source;
              upd.new_src = src_r;
            end
            default: begin
              res.valid = 1'b0;
            end
          endcase
        end else if (fin) begin
          res.valid = 1'b1;
          res.id    = id_r;
          res.last  = 1'b1;
          case (cmd_r)
            CMD_ADD: begin
              // Append a fresh entry behind the used ones.
              ram_we              = 1'b1;
              ram_waddr           = used[IDX_W-1:0];
              ram_wdata           = '0;
              ram_wdata.id        = id_r;
              ram_wdata.profile   = prof_r;
              ram_wdata.last_seen = now_r;
              res.status  = RS_ADDED;
              res.profile = prof_r;
              upd.add     = 1'b1;
            end
            default: begin
              res.status = RS_NOT_FOUND;
            end
          endcase
        end
      end

      S_SWEEP1: begin
        // First pass only counts, so that every result carries final totals.
        if (expired) begin
          off_cnt_nxt = off_cnt_r + CNT_W'(1);
        end
        if (fin) begin
          upd.sweep_sub = 1'b1;
          upd.off_cnt   = off_cnt_r;
          rd_idx_nxt    = '0;
        end
      end

      S_SWEEP2: begin
        // Second pass marks the expired entries offline and reports each.
        if (expired) begin
          ram_we           = 1'b1;
          ram_wdata.online = 1'b0;
          res.valid   = 1'b1;
          res.status  = RS_WENT_OFFLINE;
          res.id      = ram_rdata.id;
          res.profile = ram_rdata.profile;
          res.relays  = ram_rdata.relays;
          res.source  = ram_rdata.source;
          res.alert   = AL_WARNING;
        end else if (fin) begin
          res.valid  = 1'b1;
          res.status = RS_SWEEP_DONE;
          res.last   = 1'b1;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_idx_r  <= '0;
      pidx_r    <= '0;
      pv_r      <= 1'b0;
      off_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pidx_r    <= pidx_nxt;
      pv_r      <= pv_nxt;
      off_cnt_r <= off_cnt_nxt;
    end
  end

  // Command fields, held for the whole transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      id_r    <= in_device_id;
      prof_r  <= in_profile;
      relay_r <= in_relay_state;
      src_r   <= in_control_source;
      now_r   <= in_now_ms;
    end
  end

  // The memory is only written while scanning or ending a sweep.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_SWEEP2))
    else $error("entry memory written outside a scan");

  // A read in flight always concerns a used entry.
  a_read_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (CNT_W'(pidx_r) < used))
    else $error("read in flight beyond the used entries");

endmodule
